FILE: design/dmp_pkg.sv
// Shared types and constants for the dot-matrix printer command parser.
// Used by dmp_ctrl, dmp_datapath and the top level; no dependencies.
package dmp_pkg;

  // Width of the vertical cursor and the paper height
  localparam int unsigned YW = 32;
  localparam int unsigned DivCntW = $clog2(YW + 1);

  // Item function codes
  localparam logic [1:0] FN_DATA  = 2'd0;
  localparam logic [1:0] FN_CLOSE = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_MARGIN = 2'd1;
  localparam logic [1:0] CFG_PAGE   = 2'd2;

  // Style bit positions
  localparam int unsigned SB_BOLD  = 0;
  localparam int unsigned SB_UNDER = 1;
  localparam int unsigned SB_ITAL  = 2;
  localparam int unsigned SB_COND  = 3;
  localparam int unsigned SB_WIDE  = 4;
  localparam int unsigned SB_ELITE = 5;
  localparam int unsigned SB_PROP  = 6;

  typedef enum logic [2:0] {
    K_GLYPH = 3'd0,
    K_FLUSH = 3'd1,
    K_CR    = 3'd2,
    K_VMOVE = 3'd3,
    K_GCOL  = 3'd4,
    K_PAGE  = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    PS_TEXT, PS_ESC, PS_UNDER, PS_WIDE, PS_PROP, PS_SCRIPT, PS_MASTER,
    PS_FEED, PS_SPA, PS_SP3, PS_N1, PS_N2, PS_GDATA
  } ps_e;

  // What an item does, as seen before its state update
  typedef enum logic [3:0] {
    CLS_NONE, CLS_ESCLIKE, CLS_FF, CLS_CR, CLS_LF, CLS_FEED, CLS_GLYPH,
    CLS_GCOL, CLS_CLOSE
  } cls_e;

  typedef enum logic [1:0] {
    YS_PITCH, YS_BYTE, YS_FF
  } ysel_e;

  typedef enum logic [3:0] {
    CS_IDLE, CS_DECODE, CS_PREFLUSH, CS_APPLY, CS_GLYPH, CS_FULLFLUSH,
    CS_DIV, CS_ADDY, CS_GROW, CS_VMOVE, CS_CR, CS_GCOL, CS_PAGE
  } ctl_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]    kind;
    logic [7:0]    value;
    logic [YW-1:0] cursor_y;
    logic [YW-1:0] paper_height;
    logic          x_to_margin;
    logic [2:0]    dot_width;
    logic [6:0]    style_flags;
    logic [1:0]    script_mode;
    logic          last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic  load;
    logic  init;
    logic  apply;
    logic  div_start;
    logic  addy;
    ysel_e ysel;
    logic  grow;
    logic  emit;
    logic  clr_pend;
    kind_e kind;
    logic  xm;
    logic  last;
  } dmp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cls_e cls;
    logic pend_nz;
    logic need_init;
    logic line_full;
    logic glyph_nz;
    logic div_busy;
    logic out_free;
  } dmp_status_t;

endpackage

FILE: design/dmp_ctrl.sv
// Sequencing controller for the printer command parser.
// Depends on dmp_pkg; drives dmp_datapath through dmp_cmd_t.
module dmp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dmp_pkg::dmp_status_t status_i,
  output dmp_pkg::dmp_cmd_t    cmd_o
);
  import dmp_pkg::*;

  ctl_e state_q, state_d;
  cls_e cls_q, cls_d;

  // State and captured class
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      cls_q   <= CLS_NONE;
    end else begin
      state_q <= state_d;
      cls_q   <= cls_d;
    end
  end

  assign in_stall_o = (state_q != CS_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    cls_d   = cls_q;
    unique case (state_q)
      CS_IDLE: if (in_valid_i) state_d = CS_DECODE;
      CS_DECODE: begin
        if (!status_i.need_init) begin
          cls_d = status_i.cls;
          if (status_i.pend_nz && (status_i.cls == CLS_ESCLIKE || status_i.cls == CLS_FF ||
              status_i.cls == CLS_CR || status_i.cls == CLS_LF ||
              status_i.cls == CLS_CLOSE)) begin
            state_d = CS_PREFLUSH;
          end else begin
            state_d = CS_APPLY;
          end
        end
      end
      CS_PREFLUSH: if (status_i.out_free) state_d = CS_APPLY;
      CS_APPLY: begin
        unique case (cls_q)
          CLS_CR:    state_d = CS_CR;
          CLS_LF:    state_d = CS_ADDY;
          CLS_FEED:  state_d = CS_ADDY;
          CLS_FF:    state_d = CS_DIV;
          CLS_GCOL:  state_d = CS_GCOL;
          CLS_CLOSE: state_d = CS_PAGE;
          CLS_GLYPH: begin
            if (status_i.glyph_nz)       state_d = CS_GLYPH;
            else if (status_i.line_full) state_d = CS_FULLFLUSH;
            else                         state_d = CS_IDLE;
          end
          default:   state_d = CS_IDLE;
        endcase
      end
      CS_GLYPH: begin
        if (status_i.out_free) state_d = status_i.line_full ? CS_FULLFLUSH : CS_IDLE;
      end
      CS_FULLFLUSH: if (status_i.out_free) state_d = CS_ADDY;
      CS_DIV:       if (!status_i.div_busy) state_d = CS_ADDY;
      CS_ADDY:      state_d = CS_GROW;
      CS_GROW:      state_d = CS_VMOVE;
      CS_VMOVE, CS_CR, CS_GCOL, CS_PAGE: if (status_i.out_free) state_d = CS_IDLE;
      default:      state_d = CS_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = K_GLYPH;
    cmd_o.ysel = YS_PITCH;
    unique case (state_q)
      CS_IDLE:   cmd_o.load = in_valid_i;
      CS_DECODE: cmd_o.init = status_i.need_init;
      CS_PREFLUSH: begin
        cmd_o.emit     = status_i.out_free;
        cmd_o.clr_pend = status_i.out_free;
        cmd_o.kind     = K_FLUSH;
        cmd_o.last     = (cls_q == CLS_ESCLIKE);
      end
      CS_APPLY: begin
        cmd_o.apply     = 1'b1;
        cmd_o.div_start = (cls_q == CLS_FF);
      end
      CS_GLYPH: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.kind = K_GLYPH;
        cmd_o.last = !status_i.line_full;
      end
      CS_FULLFLUSH: begin
        cmd_o.emit     = status_i.out_free;
        cmd_o.clr_pend = status_i.out_free;
        cmd_o.kind     = K_FLUSH;
      end
      CS_DIV: ;
      CS_ADDY: begin
        cmd_o.addy = 1'b1;
        if (cls_q == CLS_FEED)    cmd_o.ysel = YS_BYTE;
        else if (cls_q == CLS_FF) cmd_o.ysel = YS_FF;
        else                      cmd_o.ysel = YS_PITCH;
      end
      CS_GROW: cmd_o.grow = 1'b1;
      CS_VMOVE: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.kind = K_VMOVE;
        cmd_o.xm   = (cls_q != CLS_FEED);
        cmd_o.last = 1'b1;
      end
      CS_CR: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.kind = K_CR;
        cmd_o.last = 1'b1;
      end
      CS_GCOL: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.kind = K_GCOL;
        cmd_o.last = 1'b1;
      end
      CS_PAGE: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.kind = K_PAGE;
        cmd_o.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Checks
  a_div_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_busy |-> state_q == CS_DIV)
    else $error("divider busy outside the wait state");

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == CS_DECODE)
    else $error("accepted transaction not decoded");

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("result emitted into a full output register");

  a_ff_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> status_i.div_busy)
    else $error("divider did not start");

endmodule

FILE: design/dmp_datapath.sv
// Datapath of the printer command parser: state, config, remainder divider, output register.
// Depends on dmp_pkg; commanded by dmp_ctrl.
module dmp_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dmp_pkg::in_item_t    in_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output dmp_pkg::out_item_t   out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  input  dmp_pkg::dmp_cmd_t    cmd_i,
  output dmp_pkg::dmp_status_t status_o
);
  import dmp_pkg::*;

  // Control bytes and escape letters
  localparam logic [7:0] B_ESC = 8'd27;
  localparam logic [7:0] B_SI  = 8'd15;
  localparam logic [7:0] B_DC2 = 8'd18;
  localparam logic [7:0] B_FF  = 8'd12;
  localparam logic [7:0] B_CR  = 8'd13;
  localparam logic [7:0] B_LF  = 8'd10;
  localparam logic [7:0] B_EOL = 8'd155;
  localparam logic [7:0] E_K = 8'h4B, E_L = 8'h4C, E_Y = 8'h59, E_Z = 8'h5A;
  localparam logic [7:0] E_A = 8'h41, E_3 = 8'h33, E_J = 8'h4A;
  localparam logic [7:0] E_E = 8'h45, E_G = 8'h47, E_F = 8'h46, E_H = 8'h48;
  localparam logic [7:0] E_4 = 8'h34, E_5 = 8'h35, E_DASH = 8'h2D, E_W = 8'h57;
  localparam logic [7:0] E_M = 8'h4D, E_P = 8'h50, E_LP = 8'h70, E_S = 8'h53;
  localparam logic [7:0] E_T = 8'h54, E_BANG = 8'h21;
  localparam logic [7:0] E_0 = 8'h30, E_1 = 8'h31, E_2 = 8'h32;
  localparam logic [YW+1:0] YMAX = {2'b00, {YW{1'b1}}};

  // Configuration
  logic        en_q;
  logic [15:0] margin_q, page_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b1;
      margin_q <= 16'd0;
      page_q   <= 16'd2376;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE: en_q     <= cfg_wdata_i[0];
        CFG_MARGIN: margin_q <= cfg_wdata_i;
        CFG_PAGE:   page_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [15:0] pl;
  assign pl = (page_q == 16'd0) ? 16'd1 : page_q;

  // Parser state
  in_item_t      item_q;
  ps_e           ps_q, ps_a;
  logic [6:0]    st_q, st_a;
  logic [1:0]    sc_q, sc_a;
  logic [9:0]    pitch_q, pitch_a;
  logic [1:0]    dens_q, dens_a;
  logic [15:0]   exp_q, exp_a, rcv_q, rcv_a, e_sum, r_inc;
  logic [7:0]    pend_q, pend_a, limit;
  logic          skip_q, skip_a, rdy_q, rdy_a, apply_init;
  logic [YW-1:0] y_q, pap_q;
  logic [7:0]    b;
  logic          on_bit;
  cls_e          cls_w;

  assign b      = item_q.data_byte;
  assign on_bit = (b == E_1) || (b == 8'd1);
  assign e_sum  = exp_q + {b, 8'h00};
  assign r_inc  = rcv_q + 16'd1;

  // Item classification
  always_comb begin
    cls_w = CLS_NONE;
    if (en_q) begin
      case (item_q.func)
        FN_CLOSE: cls_w = CLS_CLOSE;
        FN_DATA: begin
          if (!skip_q) begin
            case (ps_q)
              PS_TEXT: begin
                case (b)
                  B_ESC, B_SI, B_DC2: cls_w = CLS_ESCLIKE;
                  B_FF:               cls_w = CLS_FF;
                  B_CR:               cls_w = CLS_CR;
                  B_LF, B_EOL:        cls_w = CLS_LF;
                  default:            cls_w = CLS_GLYPH;
                endcase
              end
              PS_FEED:  cls_w = CLS_FEED;
              PS_GDATA: cls_w = CLS_GCOL;
              default:  cls_w = CLS_NONE;
            endcase
          end
        end
        default: cls_w = CLS_NONE;
      endcase
    end
  end

  assign status_o.cls       = cls_w;
  assign limit              = st_q[SB_COND] ? 8'd132 : (st_q[SB_ELITE] ? 8'd96 : 8'd80);
  assign status_o.line_full = (pend_q >= limit);
  assign status_o.pend_nz   = (pend_q != 8'd0);
  assign status_o.glyph_nz  = (b[6:0] != 7'd0);
  assign status_o.need_init = en_q && (item_q.func == FN_DATA) && !skip_q && !rdy_q;

  // State update for the item, apart from emitted events
  always_comb begin
    ps_a = ps_q; st_a = st_q; sc_a = sc_q; pitch_a = pitch_q; dens_a = dens_q;
    exp_a = exp_q; rcv_a = rcv_q; pend_a = pend_q; skip_a = skip_q; rdy_a = rdy_q;
    apply_init = 1'b0;
    if (en_q) begin
      case (item_q.func)
        FN_DATA: begin
          if (skip_q) begin
            if (item_q.frame_last) skip_a = 1'b0;
          end else begin
            ps_a = PS_TEXT;
            case (ps_q)
              PS_TEXT: begin
                case (b)
                  B_ESC: ps_a = PS_ESC;
                  B_SI:  st_a[SB_COND] = 1'b1;
                  B_DC2: st_a[SB_COND] = 1'b0;
                  B_EOL: if (!item_q.frame_last) skip_a = 1'b1;
                  B_FF, B_CR, B_LF: ;
                  default: begin
                    if (b[7]) st_a[SB_ITAL] = 1'b1;
                    if (b[6:0] != 7'd0) pend_a = pend_q + 8'd1;
                  end
                endcase
              end
              PS_ESC: begin
                case (b)
                  E_K:      begin dens_a = 2'd2; ps_a = PS_N1; end
                  E_L, E_Y: begin dens_a = 2'd1; ps_a = PS_N1; end
                  E_Z:      begin dens_a = 2'd0; ps_a = PS_N1; end
                  E_A:      ps_a = PS_SPA;
                  E_3:      ps_a = PS_SP3;
                  E_J:      ps_a = PS_FEED;
                  E_E, E_G: st_a[SB_BOLD] = 1'b1;
                  E_F, E_H: st_a[SB_BOLD] = 1'b0;
                  E_4:      st_a[SB_ITAL] = 1'b1;
                  E_5:      st_a[SB_ITAL] = 1'b0;
                  E_DASH:   ps_a = PS_UNDER;
                  E_W:      ps_a = PS_WIDE;
                  E_M:      st_a[SB_ELITE] = 1'b1;
                  E_P:      st_a[SB_ELITE] = 1'b0;
                  E_LP:     ps_a = PS_PROP;
                  E_S:      ps_a = PS_SCRIPT;
                  E_T:      sc_a = 2'd0;
                  E_BANG:   ps_a = PS_MASTER;
                  E_0:      pitch_a = 10'd27;
                  E_1:      pitch_a = 10'd21;
                  E_2:      pitch_a = 10'd36;
                  default: ;
                endcase
              end
              PS_UNDER:  st_a[SB_UNDER] = on_bit;
              PS_WIDE:   st_a[SB_WIDE] = on_bit;
              PS_PROP:   st_a[SB_PROP] = on_bit;
              PS_SCRIPT: sc_a = ((b == E_0) || (b == 8'd0)) ? 2'd1 : 2'd2;
              PS_MASTER: st_a = {b[1], b[0], b[5], b[2], b[6], b[7], |b[4:3]};
              PS_SPA:    pitch_a = {2'b00, b} + {1'b0, b, 1'b0};
              PS_SP3:    pitch_a = {2'b00, b};
              PS_N1: begin
                exp_a = {8'h00, b};
                ps_a  = PS_N2;
              end
              PS_N2: begin
                exp_a = e_sum;
                rcv_a = 16'd0;
                ps_a  = (e_sum != 16'd0) ? PS_GDATA : PS_TEXT;
              end
              PS_GDATA: begin
                rcv_a = r_inc;
                ps_a  = (r_inc >= exp_q) ? PS_TEXT : PS_GDATA;
              end
              default: ;
            endcase
          end
        end
        FN_CLOSE: skip_a = 1'b0;
        FN_CLEAR: begin
          skip_a = 1'b0; pend_a = 8'd0; exp_a = 16'd0; rcv_a = 16'd0; ps_a = PS_TEXT;
          apply_init = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Remainder of cursor_y by the page length, one bit a cycle
  logic [15:0]        rem_q;
  logic [16:0]        rem_sh;
  logic [YW-1:0]      dq_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;

  assign rem_sh           = {rem_q, dq_q[YW-1]};
  assign status_o.div_busy = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      busy_q <= 1'b1;
      cnt_q  <= DivCntW'(YW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= 16'd0;
      dq_q  <= y_q;
    end else if (busy_q) begin
      dq_q  <= {dq_q[YW-2:0], 1'b0};
      rem_q <= (rem_sh >= {1'b0, pl}) ? 16'(rem_sh - {1'b0, pl}) : rem_sh[15:0];
    end
  end

  // Cursor arithmetic with saturation
  logic [YW+1:0] y_sum, y_new, pap_sum, pap_new;
  logic          grow_hit;

  always_comb begin
    case (cmd_i.ysel)
      YS_BYTE: y_sum = {2'b00, y_q} + {{(YW-6){1'b0}}, b};
      YS_FF:   y_sum = {2'b00, y_q} - {{(YW-14){1'b0}}, rem_q}
                     + {{(YW-14){1'b0}}, pl} + {{(YW-14){1'b0}}, margin_q};
      default: y_sum = {2'b00, y_q} + {{(YW-8){1'b0}}, pitch_q};
    endcase
    y_new    = (y_sum > YMAX) ? YMAX : y_sum;
    grow_hit = ({2'b00, y_q} + {{(YW-14){1'b0}}, margin_q}) > {2'b00, pap_q};
    pap_sum  = {2'b00, pap_q} + {{(YW-14){1'b0}}, pl};
    pap_new  = (pap_sum > YMAX) ? YMAX : pap_sum;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q <= PS_TEXT; st_q <= 7'd0; sc_q <= 2'd0; pitch_q <= 10'd36; dens_q <= 2'd0;
      exp_q <= 16'd0; rcv_q <= 16'd0; pend_q <= 8'd0; skip_q <= 1'b0; rdy_q <= 1'b0;
      y_q <= '0; pap_q <= '0;
    end else begin
      if (cmd_i.init || (cmd_i.apply && apply_init)) begin
        pap_q <= YW'(pl); y_q <= YW'(margin_q); pitch_q <= 10'd36;
        st_q <= 7'd0; sc_q <= 2'd0; rdy_q <= 1'b1;
        if (cmd_i.apply) begin
          ps_q <= ps_a; exp_q <= exp_a; rcv_q <= rcv_a; pend_q <= pend_a; skip_q <= skip_a;
        end
      end else if (cmd_i.apply) begin
        ps_q <= ps_a; st_q <= st_a; sc_q <= sc_a; pitch_q <= pitch_a; dens_q <= dens_a;
        exp_q <= exp_a; rcv_q <= rcv_a; pend_q <= pend_a; skip_q <= skip_a; rdy_q <= rdy_a;
      end
      if (cmd_i.clr_pend) pend_q <= 8'd0;
      if (cmd_i.addy) y_q <= y_new[YW-1:0];
      if (cmd_i.grow && grow_hit) pap_q <= pap_new[YW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
  end

  // Output register
  logic      out_valid_q;
  out_item_t out_q, res;
  logic [6:0] g;

  assign g = ((b[6:0] < 7'd32) || (b[6:0] > 7'd126)) ? 7'd32 : b[6:0];

  always_comb begin
    res              = '0;
    res.kind         = cmd_i.kind;
    res.cursor_y     = y_q;
    res.paper_height = pap_q;
    res.x_to_margin  = cmd_i.xm;
    res.style_flags  = st_q;
    res.script_mode  = sc_q;
    res.last         = cmd_i.last;
    if (cmd_i.kind == K_GLYPH) res.value = {1'b0, g};
    if (cmd_i.kind == K_GCOL) begin
      res.value     = b;
      res.dot_width = (dens_q == 2'd2) ? 3'd4 : ((dens_q == 2'd1) ? 3'd2 : 3'd1);
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)               out_valid_q <= 1'b0;
    else if (cmd_i.emit)       out_valid_q <= 1'b1;
    else if (!out_stall_i)     out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/dot_matrix_printer_command_parser_unit.sv
// Printer command parser, top level: controller plus datapath.
// The first byte after reset takes longer than later ones, since it initialises the state first;
// a form feed result waits for the bit-serial remainder unit. Output stalls delay every result.
// One transaction at a time: the input stalls until the current one is done.
// Reset (rst_ni, asynchronous) restores text state, default registers and no paper.
// Depends on dmp_pkg, dmp_ctrl and dmp_datapath.
module dot_matrix_printer_command_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dmp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dmp_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import dmp_pkg::*;

  dmp_cmd_t    cmd;
  dmp_status_t status;

  dmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dmp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
